@@ sv/hws_pkg.sv @@
// ----------------------------------------------------------------------------
// hws_pkg
// Shared constants and types for the homogeneous window smoothing block.
// ----------------------------------------------------------------------------
`default_nettype none
package hws_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 4096;
  localparam int WIN          = 5;
  localparam int SUB          = 3;
  localparam int NSUB         = SUB * SUB;
  localparam int LINES        = WIN - 1;
  localparam int PIX_W        = 8;
  localparam int COL_W        = 11;
  localparam int ROW_W        = 12;
  localparam int WREG_W       = 12;
  localparam int HREG_W       = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 13;
  localparam int SCORE_W      = 12;
  localparam int PROD_W       = 24;
  localparam int RECIP        = 3641;   // ceil(2^15 / 9)
  localparam int RECIP_SHIFT  = 15;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_t;

  // request entering the line stores
  typedef struct packed {
    logic             valid;
    logic             emit;
    logic [1:0]       line;
    logic [PIX_W-1:0] px;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } in_meta_t;

  // result bookkeeping alongside the select pipeline
  typedef struct packed {
    logic             emit;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } res_meta_t;

endpackage
`default_nettype wire

@@ sv/hws_ram.sv @@
// ----------------------------------------------------------------------------
// hws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module hws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a read and write at one address return the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ sv/hws_cell.sv @@
// ----------------------------------------------------------------------------
// hws_cell
// One window pixel: loads its right-hand neighbor's value on each shift.
// ----------------------------------------------------------------------------
`default_nettype none
module hws_cell import hws_pkg::*; (
  input  wire logic             clk,
  input  wire logic             shift,
  input  wire logic [PIX_W-1:0] d,
  output logic      [PIX_W-1:0] q
);

  logic [PIX_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

@@ sv/hws_select.sv @@
// ----------------------------------------------------------------------------
// hws_select
// Scores the nine 3x3 sub-windows, picks the flattest, returns its mean.
// ----------------------------------------------------------------------------
`default_nettype none
module hws_select import hws_pkg::*; (
  input  wire logic             clk,
  input  wire logic             adv,
  input  wire win_t             win,
  output logic      [PIX_W-1:0] mean
);

  logic [SCORE_W-1:0] score_nxt [NSUB];
  logic [SCORE_W-1:0] sum_nxt   [NSUB];
  logic [SCORE_W-1:0] score_r   [NSUB];
  logic [SCORE_W-1:0] sum_r     [NSUB];
  logic [SCORE_W-1:0] best_nxt;
  logic [SCORE_W-1:0] best_r;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    logic [PIX_W-1:0]   ctr;
    logic [PIX_W-1:0]   dif [WIN][WIN];
    logic [SCORE_W-1:0] sc;
    logic [SCORE_W-1:0] sm;
    ctr = win[2][2];
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN; c++) begin
        dif[r][c] = (win[r][c] > ctr) ? win[r][c] - ctr : ctr - win[r][c];
      end
    end
    for (int i = 0; i < SUB; i++) begin
      for (int j = 0; j < SUB; j++) begin
        sc = '0;
        sm = '0;
        for (int a = 0; a < SUB; a++) begin
          for (int b = 0; b < SUB; b++) begin
            sc = sc + SCORE_W'(dif[i+a][j+b]);
            sm = sm + SCORE_W'(win[i+a][j+b]);
          end
        end
        score_nxt[i*SUB+j] = sc;
        sum_nxt[i*SUB+j]   = sm;
      end
    end
  end

  // strict less-than keeps the first sub-window on a tie
  always_comb begin
    logic [SCORE_W-1:0] bs;
    bs       = score_r[0];
    best_nxt = sum_r[0];
    for (int k = 1; k < NSUB; k++) begin
      if (score_r[k] < bs) begin
        bs       = score_r[k];
        best_nxt = sum_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      score_r <= score_nxt;
      sum_r   <= sum_nxt;
      best_r  <= best_nxt;
    end
  end

  // divide by nine through a reciprocal; exact for sums below 2300
  assign prod = PROD_W'(best_r + SCORE_W'(4)) * PROD_W'(RECIP);
  assign mean = prod[RECIP_SHIFT +: PIX_W];

endmodule
`default_nettype wire

@@ sv/homogeneous_window_smoothing_top.sv @@
// ----------------------------------------------------------------------------
// homogeneous_window_smoothing_top
// Selective 5x5 smoothing over a raster-order grey pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the result side keeps up; a stalled result
// stalls the whole pipeline. Each interior pixel yields one result after the
// pixel that completes its window is accepted, registered in turn through line store
// read, window shift, sub-window scoring, minimum select, divide and output
// register. Border pixels give no result. Four line-store RAMs sized for the
// widest image feed a 5x5 array of shifting pixel cells. Write image_width and
// image_height only between frames while the block is idle.
`default_nettype none
module homogeneous_window_smoothing_top import hws_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [PIX_W-1:0]      in_pixel_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [PIX_W-1:0]      out_smoothed_value,
  output logic      [COL_W-1:0]      out_center_column,
  output logic      [ROW_W-1:0]      out_center_row,
  output logic                       out_frame_last,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WREG_W-1:0] width_r;
  logic [HREG_W-1:0] height_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [WREG_W-1:0] w_eff;
  logic [HREG_W-1:0] h_eff;
  logic              row_end;
  logic              frame_end;
  logic              adv;
  logic              accept;
  in_meta_t          s1_r;
  in_meta_t          s1_nxt;
  res_meta_t         s2_r;
  res_meta_t         s3_r;
  res_meta_t         s4_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_val_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic              out_last_r;
  logic [PIX_W-1:0]  line_q [LINES];
  win_t              win;
  logic [PIX_W-1:0]  mean;
  logic              shift;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;
  assign shift    = adv && s1_r.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WREG_W'(640);
      height_r <= HREG_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[WREG_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) w_eff = WREG_W'(1);
    else if (width_r > WREG_W'(MAX_WIDTH)) w_eff = WREG_W'(MAX_WIDTH);
    else w_eff = width_r;
    if (height_r == '0) h_eff = HREG_W'(1);
    else if (height_r > HREG_W'(MAX_HEIGHT)) h_eff = HREG_W'(MAX_HEIGHT);
    else h_eff = height_r;
  end

  assign row_end   = (WREG_W'(col_r) + WREG_W'(1)) >= w_eff;
  assign frame_end = row_end && ((HREG_W'(row_r) + HREG_W'(1)) >= h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= frame_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_comb begin
    s1_nxt.valid = accept;
    s1_nxt.emit  = (row_r >= ROW_W'(4)) && (col_r >= COL_W'(4));
    s1_nxt.line  = row_r[1:0];
    s1_nxt.px    = in_pixel_value;
    s1_nxt.col   = col_r - COL_W'(2);
    s1_nxt.row   = row_r - ROW_W'(2);
    s1_nxt.last  = frame_end;
  end

  // one line store per row slot; the current row overwrites the oldest
  for (genvar l = 0; l < LINES; l++) begin : g_line
    hws_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (accept && (row_r[1:0] == 2'(l))),
      .waddr (col_r),
      .wdata (in_pixel_value),
      .re    (accept),
      .raddr (col_r),
      .rdata (line_q[l])
    );
  end

  for (genvar k = 0; k < WIN; k++) begin : g_row
    logic [1:0]       sel;
    logic [PIX_W-1:0] col_in;
    assign sel = s1_r.line + 2'(k);
    assign col_in = (k == WIN - 1) ? s1_r.px : line_q[sel];
    for (genvar j = 0; j < WIN; j++) begin : g_col
      hws_cell u_cell (
        .clk   (clk),
        .shift (shift),
        .d     ((j == WIN - 1) ? col_in : win[k][(j + 1) % WIN]),
        .q     (win[k][j])
      );
    end
  end

  hws_select u_select (
    .clk  (clk),
    .adv  (adv),
    .win  (win),
    .mean (mean)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid  <= 1'b0;
      s2_r.emit   <= 1'b0;
      s3_r.emit   <= 1'b0;
      s4_r.emit   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_r        <= s1_nxt;
      s2_r.emit   <= s1_r.valid && s1_r.emit;
      s3_r.emit   <= s2_r.emit;
      s4_r.emit   <= s3_r.emit;
      out_valid_r <= s4_r.emit;
      s2_r.col    <= s1_r.col;
      s2_r.row    <= s1_r.row;
      s2_r.last   <= s1_r.last;
      s3_r.col    <= s2_r.col;
      s3_r.row    <= s2_r.row;
      s3_r.last   <= s2_r.last;
      s4_r.col    <= s3_r.col;
      s4_r.row    <= s3_r.row;
      s4_r.last   <= s3_r.last;
      out_val_r   <= mean;
      out_col_r   <= s4_r.col;
      out_row_r   <= s4_r.row;
      out_last_r  <= s4_r.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed_value = out_val_r;
  assign out_center_column  = out_col_r;
  assign out_center_row     = out_row_r;
  assign out_frame_last     = out_last_r;

endmodule
`default_nettype wire

@@ sv/hws_checker.sv @@
// ----------------------------------------------------------------------------
// hws_checker
// Port-level checks for the smoothing block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module hws_checker import hws_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [PIX_W-1:0] out_smoothed_value,
  input wire logic [COL_W-1:0] out_center_column,
  input wire logic [ROW_W-1:0] out_center_row
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_smoothed_value))
    else $error("result request dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_center_column >= COL_W'(2)) && (out_center_row >= ROW_W'(2)))
    else $error("result for a border pixel");

endmodule

bind homogeneous_window_smoothing_top hws_checker u_hws_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_smoothed_value (out_smoothed_value),
  .out_center_column  (out_center_column),
  .out_center_row     (out_center_row)
);
`default_nettype wire
